[rtl/core/itlu_pkg.sv]
`default_nettype none

package itlu_pkg;

   // Fixed widths of the item fields
   localparam int FIELD_W = 32;
   localparam int IDX_W   = 12;
   localparam int CNT_W   = 13;

   // Operation codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Result status codes
   localparam logic [1:0] STATUS_INTERP     = 2'd0;
   localparam logic [1:0] STATUS_CLAMP_LOW  = 2'd1;
   localparam logic [1:0] STATUS_CLAMP_HIGH = 2'd2;
   localparam logic [1:0] STATUS_NOT_VALID  = 2'd3;

   typedef struct packed {
      logic               operation;
      logic [IDX_W-1:0]   entry_index;
      logic [FIELD_W-1:0] entry_key;
      logic [FIELD_W-1:0] entry_value;
      logic [FIELD_W-1:0] query_key;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0] result_value;
      logic [1:0]         status;
   } rsp_type;

   // Lookup sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_LAST,
      ST_SEARCH,
      ST_CALC,
      ST_DIVIDE
   } state_type;

   // Multiply-divide unit phases
   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_DIV
   } md_phase_type;

   // Multiply-divide unit status toward the sequencer
   typedef struct packed {
      logic done;
      logic inexact;
   } md_status_type;

endpackage

`default_nettype wire

[rtl/core/itlu_ram.sv]
`default_nettype none

module itlu_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word with a registered output
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/itlu_muldiv.sv]
`default_nettype none

// Floor of a*b/c for a <= c, c > 0: a multiply, then one
// restoring division step per quotient bit.
module itlu_muldiv #(
   parameter int WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [WIDTH-1:0]      a,
   input  wire logic [WIDTH-1:0]      b,
   input  wire logic [WIDTH-1:0]      c,
   output logic      [WIDTH-1:0]      quotient,
   output itlu_pkg::md_status_type    md_status
);

   localparam int STEP_W = $clog2(WIDTH);

   itlu_pkg::md_phase_type phase_ff, phase_in;
   logic [WIDTH-1:0]   a_ff, a_in;
   logic [WIDTH-1:0]   b_ff, b_in;
   logic [WIDTH-1:0]   c_ff, c_in;
   logic [WIDTH-1:0]   rem_ff, rem_in;
   logic [WIDTH-1:0]   low_ff, low_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               done_ff, done_in;
   logic [2*WIDTH-1:0] prod;
   logic [WIDTH:0]     trial;
   logic [WIDTH:0]     diff;
   logic               qbit;

   // Advance phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         itlu_pkg::MD_IDLE: begin
            if (start) begin
               phase_in = itlu_pkg::MD_MUL;
            end
         end
         itlu_pkg::MD_MUL: begin
            phase_in = itlu_pkg::MD_DIV;
         end
         itlu_pkg::MD_DIV: begin
            if (step_ff == '0) begin
               phase_in = itlu_pkg::MD_IDLE;
            end
         end
         default: begin
            phase_in = itlu_pkg::MD_IDLE;
         end
      endcase
   end

   // Multiply once, then shift in one quotient bit per cycle
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      c_in    = c_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      step_in = step_ff;
      done_in = 1'b0;
      prod    = (2*WIDTH)'(a_ff) * (2*WIDTH)'(b_ff);
      trial   = {rem_ff, low_ff[WIDTH-1]};
      diff    = trial - {1'b0, c_ff};
      qbit    = (trial >= {1'b0, c_ff});
      unique case (phase_ff)
         itlu_pkg::MD_IDLE: begin
            if (start) begin
               a_in = a;
               b_in = b;
               c_in = c;
            end
         end
         itlu_pkg::MD_MUL: begin
            rem_in  = prod[2*WIDTH-1:WIDTH];
            low_in  = prod[WIDTH-1:0];
            step_in = STEP_W'(WIDTH - 1);
         end
         itlu_pkg::MD_DIV: begin
            if (qbit) begin
               rem_in = diff[WIDTH-1:0];
            end else begin
               rem_in = trial[WIDTH-1:0];
            end
            low_in  = {low_ff[WIDTH-2:0], qbit};
            step_in = step_ff - STEP_W'(1);
            done_in = (step_ff == '0);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= itlu_pkg::MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      c_ff    <= c_in;
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      step_ff <= step_in;
   end

   assign quotient          = low_ff;
   assign md_status.done    = done_ff;
   assign md_status.inexact = (rem_ff != '0);

endmodule

`default_nettype wire

[rtl/core/interpolating_table_lookup_unit.sv]
`default_nettype none

// Interpolating table lookup.
// Items enter on req_item when start is high and busy is low. A load item
// writes one key/value pair and finishes in the cycle it is accepted; a load
// to the last in-use position marks the table valid. A query item returns
// one result on rsp_item, flagged by rsp_valid for exactly one cycle; the
// receiver always takes it. busy drops in the cycle that shows the result,
// so the next item may be accepted there.
// A query on a table that is not valid returns zero with status not valid;
// a key at or below the first key clamps low, one at or above the last key
// clamps high; otherwise a binary search of at most ceil(log2(n-1)) reads of
// the table memory, n being the entries in use, brackets the key and the serial
// divider interpolates in W = min(FIXED_WIDTH, 32) steps.
// The table lives in one single-port-read memory holding key and value side
// by side. csr_wdata sets the number of entries in use, saturated to
// 2 .. TABLE_DEPTH; csr_ready is always high.
// Reset clears the valid flag and sets the entry count to min(TABLE_DEPTH, 4096);
// the table contents are undefined until loaded, so no clearing pass is run.
module interpolating_table_lookup_unit #(
   parameter int TABLE_DEPTH = 4096,
   parameter int FIXED_WIDTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire itlu_pkg::req_type             req_item,
   output logic                               rsp_valid,
   output itlu_pkg::rsp_type                  rsp_item,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [itlu_pkg::CNT_W-1:0]    csr_wdata
);

   localparam int SW   = (FIXED_WIDTH < 32) ? FIXED_WIDTH : 32;
   localparam int AW   = $clog2(TABLE_DEPTH);
   localparam int CW   = $clog2(TABLE_DEPTH + 1);
   localparam int CMPW = (CW > itlu_pkg::CNT_W) ? CW : itlu_pkg::CNT_W;
   localparam int IXW  = (CW > itlu_pkg::IDX_W) ? CW : itlu_pkg::IDX_W;
   localparam int LAST_RESET = ((TABLE_DEPTH < 4096) ? TABLE_DEPTH : 4096) - 1;

   itlu_pkg::state_type state_ff, state_in;
   logic [AW-1:0]       last_idx_ff, last_idx_in;
   logic                table_valid_ff, table_valid_in;
   logic [SW-1:0]       key_q_ff, key_q_in;
   logic [AW-1:0]       lo_ff, lo_in;
   logic [AW-1:0]       hi_ff, hi_in;
   logic [AW-1:0]       mid_ff, mid_in;
   logic [SW-1:0]       klo_ff, klo_in;
   logic [SW-1:0]       khi_ff, khi_in;
   logic [SW-1:0]       vlo_ff, vlo_in;
   logic [SW-1:0]       vhi_ff, vhi_in;
   logic                rsp_valid_ff, rsp_valid_in;
   itlu_pkg::rsp_type   rsp_ff, rsp_in;

   logic [CMPW-1:0]     cnt_ext;
   logic [CMPW-1:0]     cnt_clamp;
   logic [IXW-1:0]      idx_ext;
   logic                idx_ok;
   logic                accept;
   logic                load_wr;
   logic                is_query;

   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic [2*SW-1:0]     rd_data;
   logic [SW-1:0]       rd_key;
   logic [SW-1:0]       rd_val;

   logic                go_low;
   logic [AW-1:0]       lo_new;
   logic [AW-1:0]       hi_new;
   logic [AW-1:0]       gap;
   logic                more;
   logic [AW:0]         mid_sum;
   logic [AW-1:0]       mid_next;

   logic                md_start;
   logic [SW-1:0]       md_off;
   logic [SW-1:0]       md_span;
   logic [SW-1:0]       md_dv;
   logic                rising;
   logic [SW-1:0]       md_q;
   itlu_pkg::md_status_type md_status;
   logic [SW-1:0]       interp_val;

   // Saturate the entry count and keep the last in-use index
   always_comb begin
      cnt_ext = CMPW'(csr_wdata);
      priority if (cnt_ext < CMPW'(2)) begin
         cnt_clamp = CMPW'(2);
      end else if (cnt_ext > CMPW'(TABLE_DEPTH)) begin
         cnt_clamp = CMPW'(TABLE_DEPTH);
      end else begin
         cnt_clamp = cnt_ext;
      end
      last_idx_in = csr_valid ? AW'(cnt_clamp - CMPW'(1)) : last_idx_ff;
   end

   assign csr_ready = 1'b1;

   // Accept items; loads write the table at once
   assign busy     = (state_ff != itlu_pkg::ST_IDLE);
   assign accept   = start && !busy;
   assign is_query = (req_item.operation == itlu_pkg::OP_QUERY);
   assign idx_ext  = IXW'(req_item.entry_index);
   assign idx_ok   = (idx_ext < IXW'(TABLE_DEPTH));
   assign load_wr  = accept && !is_query && idx_ok;
   assign table_valid_in = table_valid_ff || (load_wr && idx_ext == IXW'(last_idx_ff));

   itlu_ram #(
      .WIDTH (2 * SW),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr (idx_ext[AW-1:0]),
      .wr_data ({req_item.entry_key[SW-1:0], req_item.entry_value[SW-1:0]}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_key = rd_data[2*SW-1:SW];
   assign rd_val = rd_data[SW-1:0];

   // Narrow the bracket by the entry just read
   always_comb begin
      go_low   = (rd_key < key_q_ff);
      lo_new   = go_low ? mid_ff : lo_ff;
      hi_new   = go_low ? hi_ff : mid_ff;
      gap      = hi_new - lo_new;
      more     = (gap > AW'(1));
      mid_sum  = (AW+1)'(lo_new) + (AW+1)'(hi_new);
      mid_next = mid_sum[AW:1];
   end

   // Prepare operands of the interpolation
   always_comb begin
      md_off  = key_q_ff - klo_ff;
      md_span = khi_ff - klo_ff;
      rising  = (vhi_ff >= vlo_ff);
      md_dv   = rising ? (vhi_ff - vlo_ff) : (vlo_ff - vhi_ff);
      if (rising) begin
         interp_val = vlo_ff + md_q;
      end else begin
         interp_val = vlo_ff - md_q - SW'(md_status.inexact);
      end
   end

   itlu_muldiv #(
      .WIDTH (SW)
   ) u_muldiv (
      .clock     (clock),
      .reset     (reset),
      .start     (md_start),
      .a         (md_off),
      .b         (md_dv),
      .c         (md_span),
      .quotient  (md_q),
      .md_status (md_status)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         itlu_pkg::ST_IDLE: begin
            if (accept && is_query && table_valid_ff) begin
               state_in = itlu_pkg::ST_FIRST;
            end
         end
         itlu_pkg::ST_FIRST: begin
            if (key_q_ff <= rd_key) begin
               state_in = itlu_pkg::ST_IDLE;
            end else begin
               state_in = itlu_pkg::ST_LAST;
            end
         end
         itlu_pkg::ST_LAST: begin
            priority if (key_q_ff >= rd_key) begin
               state_in = itlu_pkg::ST_IDLE;
            end else if (last_idx_ff > AW'(1)) begin
               state_in = itlu_pkg::ST_SEARCH;
            end else begin
               state_in = itlu_pkg::ST_CALC;
            end
         end
         itlu_pkg::ST_SEARCH: begin
            if (!more) begin
               state_in = itlu_pkg::ST_CALC;
            end
         end
         itlu_pkg::ST_CALC: begin
            if (khi_ff <= klo_ff) begin
               state_in = itlu_pkg::ST_IDLE;
            end else begin
               state_in = itlu_pkg::ST_DIVIDE;
            end
         end
         itlu_pkg::ST_DIVIDE: begin
            if (md_status.done) begin
               state_in = itlu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = itlu_pkg::ST_IDLE;
         end
      endcase
   end

   // Memory reads, bracket updates and results
   always_comb begin
      key_q_in     = key_q_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      klo_in       = klo_ff;
      khi_in       = khi_ff;
      vlo_in       = vlo_ff;
      vhi_in       = vhi_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      md_start     = 1'b0;
      unique case (state_ff)
         itlu_pkg::ST_IDLE: begin
            if (accept && is_query) begin
               key_q_in = req_item.query_key[SW-1:0];
               if (table_valid_ff) begin
                  rd_en   = 1'b1;
                  rd_addr = '0;
               end else begin
                  rsp_valid_in        = 1'b1;
                  rsp_in.result_value = '0;
                  rsp_in.status       = itlu_pkg::STATUS_NOT_VALID;
               end
            end
         end
         itlu_pkg::ST_FIRST: begin
            if (key_q_ff <= rd_key) begin
               rsp_valid_in        = 1'b1;
               rsp_in.result_value = itlu_pkg::FIELD_W'(rd_val);
               rsp_in.status       = itlu_pkg::STATUS_CLAMP_LOW;
            end else begin
               klo_in  = rd_key;
               vlo_in  = rd_val;
               lo_in   = '0;
               hi_in   = last_idx_ff;
               rd_en   = 1'b1;
               rd_addr = last_idx_ff;
            end
         end
         itlu_pkg::ST_LAST: begin
            if (key_q_ff >= rd_key) begin
               rsp_valid_in        = 1'b1;
               rsp_in.result_value = itlu_pkg::FIELD_W'(rd_val);
               rsp_in.status       = itlu_pkg::STATUS_CLAMP_HIGH;
            end else begin
               khi_in = rd_key;
               vhi_in = rd_val;
               if (last_idx_ff > AW'(1)) begin
                  rd_en   = 1'b1;
                  rd_addr = last_idx_ff >> 1;
               end
            end
         end
         itlu_pkg::ST_SEARCH: begin
            lo_in = lo_new;
            hi_in = hi_new;
            if (go_low) begin
               klo_in = rd_key;
               vlo_in = rd_val;
            end else begin
               khi_in = rd_key;
               vhi_in = rd_val;
            end
            if (more) begin
               rd_en   = 1'b1;
               rd_addr = mid_next;
            end
         end
         itlu_pkg::ST_CALC: begin
            if (khi_ff <= klo_ff) begin
               rsp_valid_in        = 1'b1;
               rsp_in.result_value = itlu_pkg::FIELD_W'(vlo_ff);
               rsp_in.status       = itlu_pkg::STATUS_INTERP;
            end else begin
               md_start = 1'b1;
            end
         end
         itlu_pkg::ST_DIVIDE: begin
            if (md_status.done) begin
               rsp_valid_in        = 1'b1;
               rsp_in.result_value = itlu_pkg::FIELD_W'(interp_val);
               rsp_in.status       = itlu_pkg::STATUS_INTERP;
            end
         end
         default: begin
         end
      endcase
      mid_in = rd_en ? rd_addr : mid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= itlu_pkg::ST_IDLE;
         last_idx_ff    <= AW'(LAST_RESET);
         table_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         last_idx_ff    <= last_idx_in;
         table_valid_ff <= table_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      key_q_ff <= key_q_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      klo_ff   <= klo_in;
      khi_ff   <= khi_in;
      vlo_ff   <= vlo_in;
      vhi_ff   <= vhi_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

[rtl/core/itlu_checker.sv]
`default_nettype none

module itlu_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire itlu_pkg::req_type req_item,
   input wire logic              rsp_valid,
   input wire itlu_pkg::rsp_type rsp_item
);

   // A query either occupies the block or answers at once
   a_query_starts: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.operation == itlu_pkg::OP_QUERY)
         |=> (busy || rsp_valid))
      else $error("query accepted without work or result");

   // A load finishes in its own cycle and yields nothing
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.operation == itlu_pkg::OP_LOAD)
         |=> (!busy && !rsp_valid))
      else $error("load item kept the block busy or produced a result");

   // The block only goes idle by delivering a result
   a_idle_on_result: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_valid)
      else $error("busy dropped without a result");

   // A result is shown only while idle
   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   // A query on an incomplete table answers zero
   a_not_valid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status == itlu_pkg::STATUS_NOT_VALID)
         |-> (rsp_item.result_value == '0))
      else $error("not-valid result carries a nonzero value");

endmodule

bind interpolating_table_lookup_unit itlu_checker u_itlu_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

`default_nettype wire
